/* rtl/cpp_pkg.sv */
// shared constants and types for the closed polygon perimeter block
// no dependencies; used by cpp_isqrt and closed_polygon_perimeter
package cpp_pkg;

	localparam int COORD_W      = 15;
	localparam int SCALE_W      = 8;
	localparam int FRAC_BITS    = 16;
	localparam int SQ_W         = 32;
	localparam int ROOT_W       = SQ_W / 2 + FRAC_BITS;
	localparam int REM_W        = ROOT_W + 4;
	localparam int STEP_W       = $clog2(ROOT_W);
	localparam int SUM_W        = 42;
	localparam int OUT_W        = 34;
	localparam int PROD_W       = SUM_W + SCALE_W;
	localparam int MAX_VERTICES = 1024;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int IN_TDATA_W   = 32;
	localparam int OUT_TDATA_W  = 40;

	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(5);

	// status of the square root unit
	typedef struct packed {
		logic busy;
		logic done;
	} sqrt_stat_t;

endpackage

/* rtl/closed_polygon_perimeter.sv */
// top level of the closed polygon perimeter block: sequencer, squaring,
// accumulation and final scaling; depends on cpp_pkg and cpp_isqrt
//
// Vertices arrive one per request as x (tdata bits 14:0) and y (bits 29:15),
// with tlast marking the final vertex; a run is also closed by force on its
// 1024th vertex. Each edge is squared with one shared 15x15 multiplier, x
// and y in turn, and then goes through a bit-serial root unit that yields one
// of its 32 result bits (16 integer, 16 fraction) per cycle; an edge passes
// accept, squaring of x and of y, root start, the root steps, done and
// accumulate. The first vertex of a polygon is only stored. The final vertex
// of a longer polygon adds its closing edge in a second pass, then the sum is
// scaled and the result register is loaded once the output is free. The input
// is not ready while an item is being worked on. The result carries
// ceil(cost_scale * perimeter) in tdata and the saturation flag in tuser;
// cost_scale resets to 5 and may be written only while the block is idle.
module closed_polygon_perimeter (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cost_scale_we,
	input  logic [cpp_pkg::SCALE_W-1:0]     cost_scale_wdata,
	// vertex stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [cpp_pkg::IN_TDATA_W-1:0]  s_tdata,  // x_coord, y_coord
	input  logic                            s_tlast,  // last_vertex
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cpp_pkg::OUT_TDATA_W-1:0] m_tdata,  // scaled_perimeter
	output logic                            m_tuser   // saturated
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQX,
		S_SQY,
		S_START,
		S_ROOT,
		S_ACC,
		S_MUL,
		S_FIN
	} state_t;

	state_t state_q;

	logic [cpp_pkg::SCALE_W-1:0] cost_scale_q;
	logic [cpp_pkg::COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic                        have_first_q;
	logic [cpp_pkg::SUM_W-1:0]   sum_q;
	logic                        sat_q;
	logic [cpp_pkg::CNT_W-1:0]   cnt_q;
	logic                        closing_q;
	logic                        fin_q;
	logic [cpp_pkg::COORD_W-1:0] dx_q, dy_q;
	logic [cpp_pkg::SQ_W-1:0]    sq_q;
	logic [cpp_pkg::PROD_W-1:0]  prod_q;
	logic                        out_valid_q;
	logic [cpp_pkg::OUT_W-1:0]   out_data_q;
	logic                        out_sat_q;

	logic [cpp_pkg::COORD_W-1:0] in_x, in_y;
	logic [cpp_pkg::COORD_W-1:0] ax, ay, bx, by;
	logic [cpp_pkg::COORD_W-1:0] dx, dy;
	logic [cpp_pkg::COORD_W-1:0] mul_op;
	logic [2*cpp_pkg::COORD_W-1:0] mul_res;
	logic [cpp_pkg::CNT_W-1:0]   cnt_n;
	logic                        last_eff;
	logic [cpp_pkg::SUM_W:0]     acc_t;
	logic [cpp_pkg::OUT_W:0]     q_round;
	logic                        out_free;
	logic                        sqrt_start;
	logic [cpp_pkg::ROOT_W-1:0]  root;
	cpp_pkg::sqrt_stat_t         sqrt_stat;

	assign in_x = s_tdata[cpp_pkg::COORD_W-1:0];
	assign in_y = s_tdata[2*cpp_pkg::COORD_W-1:cpp_pkg::COORD_W];

	// shared absolute difference: incoming edge while idle, closing edge otherwise
	always_comb begin
		if (state_q == S_IDLE) begin
			ax = prev_x_q;
			ay = prev_y_q;
			bx = in_x;
			by = in_y;
		end else begin
			ax = prev_x_q;
			ay = prev_y_q;
			bx = first_x_q;
			by = first_y_q;
		end
		dx = (ax > bx) ? ax - bx : bx - ax;
		dy = (ay > by) ? ay - by : by - ay;
	end

	// shared squaring multiplier
	assign mul_op  = (state_q == S_SQX) ? dx_q : dy_q;
	assign mul_res = mul_op * mul_op;

	// vertex count and forced close
	assign cnt_n    = cnt_q + 1'b1;
	assign last_eff = s_tlast || (cnt_n >= cpp_pkg::CNT_W'(cpp_pkg::MAX_VERTICES));

	// saturating accumulate of one edge length
	assign acc_t = {1'b0, sum_q} + (cpp_pkg::SUM_W + 1)'(root);

	// round the scaled sum up to an integer
	assign q_round = {1'b0, prod_q[cpp_pkg::PROD_W-1:cpp_pkg::FRAC_BITS]}
	                 + (cpp_pkg::OUT_W + 1)'(|prod_q[cpp_pkg::FRAC_BITS-1:0]);

	assign out_free   = !out_valid_q || m_tready;
	assign sqrt_start = (state_q == S_START);
	assign s_tready   = (state_q == S_IDLE);

	cpp_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sq_q),
		.root     (root),
		.stat     (sqrt_stat)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_scale_q <= cpp_pkg::SCALE_RESET;
		end else if (cost_scale_we) begin
			cost_scale_q <= cost_scale_wdata;
		end
	end

	// sequencer, polygon state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			first_x_q    <= '0;
			first_y_q    <= '0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			have_first_q <= 1'b0;
			sum_q        <= '0;
			sat_q        <= 1'b0;
			cnt_q        <= '0;
			closing_q    <= 1'b0;
			fin_q        <= 1'b0;
			dx_q         <= '0;
			dy_q         <= '0;
			sq_q         <= '0;
			prod_q       <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			out_sat_q    <= 1'b0;
		end else begin
			// drop a taken result unless a new one is loaded now
			if (out_valid_q && m_tready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cnt_q    <= cnt_n;
						prev_x_q <= in_x;
						prev_y_q <= in_y;
						if (!have_first_q) begin
							first_x_q    <= in_x;
							first_y_q    <= in_y;
							have_first_q <= 1'b1;
							if (last_eff) begin
								state_q <= S_MUL;
							end
						end else begin
							dx_q      <= dx;
							dy_q      <= dy;
							closing_q <= last_eff;
							fin_q     <= last_eff;
							state_q   <= S_SQX;
						end
					end
				end
				S_SQX: begin
					sq_q    <= cpp_pkg::SQ_W'(mul_res);
					state_q <= S_SQY;
				end
				S_SQY: begin
					sq_q    <= sq_q + cpp_pkg::SQ_W'(mul_res);
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (sqrt_stat.done) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (acc_t[cpp_pkg::SUM_W]) begin
						sum_q <= '1;
						sat_q <= 1'b1;
					end else begin
						sum_q <= acc_t[cpp_pkg::SUM_W-1:0];
					end
					if (closing_q) begin
						closing_q <= 1'b0;
						dx_q      <= dx;
						dy_q      <= dy;
						state_q   <= S_SQX;
					end else if (fin_q) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_MUL: begin
					prod_q  <= cost_scale_q * sum_q;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (q_round[cpp_pkg::OUT_W]) begin
							out_data_q <= '1;
							out_sat_q  <= 1'b1;
						end else begin
							out_data_q <= q_round[cpp_pkg::OUT_W-1:0];
							out_sat_q  <= sat_q;
						end
						first_x_q    <= '0;
						first_y_q    <= '0;
						prev_x_q     <= '0;
						prev_y_q     <= '0;
						have_first_q <= 1'b0;
						sum_q        <= '0;
						sat_q        <= 1'b0;
						cnt_q        <= '0;
						fin_q        <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = cpp_pkg::OUT_TDATA_W'(out_data_q);
	assign m_tuser  = out_sat_q;

	// an empty polygon holds no partial sum
	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		!have_first_q |-> (sum_q == '0 && !sat_q))
		else $error("partial sum left over without a first vertex");

	// the root unit is never busy while the input can take a request
	a_idle_root: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !sqrt_stat.busy)
		else $error("root unit busy while the input is ready");

	// a root only completes while the sequencer waits for it
	a_root_done: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_stat.done |-> (state_q == S_ROOT))
		else $error("root finished outside the wait state");

	// a new result only comes from the final state
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_FIN))
		else $error("result appeared without passing the final state");

endmodule

/* rtl/cpp_isqrt.sv */
// bit-serial integer square root with fraction bits, one result bit per cycle
// depends on cpp_pkg
module cpp_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cpp_pkg::SQ_W-1:0]   radicand,
	output logic [cpp_pkg::ROOT_W-1:0] root,
	output cpp_pkg::sqrt_stat_t        stat
);

	logic [cpp_pkg::SQ_W-1:0]   s_q;
	logic [cpp_pkg::REM_W-1:0]  rem_q;
	logic [cpp_pkg::ROOT_W-1:0] root_q;
	logic [cpp_pkg::STEP_W-1:0] step_q;
	logic                       busy_q;
	logic                       done_q;

	logic [cpp_pkg::REM_W-1:0]  rem_shift;
	logic [cpp_pkg::REM_W-1:0]  trial;
	logic                       fits;

	// one trial subtraction per cycle, radicand pairs fed from the top
	always_comb begin
		rem_shift = {rem_q[cpp_pkg::REM_W-3:0], s_q[cpp_pkg::SQ_W-1 -: 2]};
		trial     = cpp_pkg::REM_W'({root_q, 2'b01});
		fits      = (rem_shift >= trial);
	end

	// iteration control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == cpp_pkg::STEP_W'(cpp_pkg::ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			s_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			s_q <= {s_q[cpp_pkg::SQ_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= rem_shift - trial;
				root_q <= {root_q[cpp_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_shift;
				root_q <= {root_q[cpp_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign root      = root_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* test/testbench.sv */
// self-checking testbench for closed_polygon_perimeter: vertex stream in, perimeter out
// depends on cpp_pkg and the closed_polygon_perimeter rtl; reads no files
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_W      = cpp_pkg::COORD_W;
	localparam int SCALE_W      = cpp_pkg::SCALE_W;
	localparam int FRAC_BITS    = cpp_pkg::FRAC_BITS;
	localparam int SQ_W         = cpp_pkg::SQ_W;
	localparam int ROOT_W       = cpp_pkg::ROOT_W;
	localparam int SUM_W        = cpp_pkg::SUM_W;
	localparam int OUT_W        = cpp_pkg::OUT_W;
	localparam int PROD_W       = cpp_pkg::PROD_W;
	localparam int MAX_VERTICES = cpp_pkg::MAX_VERTICES;
	localparam int IN_TDATA_W   = cpp_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W  = cpp_pkg::OUT_TDATA_W;

	localparam int SETTLE_CYCLES = 120;
	localparam int HOLD_CYCLES   = 1500;
	localparam int MAX_REPORTS   = 10;
	localparam bit [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

	typedef struct packed {
		bit [OUT_W-1:0] perim;
		bit             sat;
	} perimeter_t;

	// running perimeter prediction and the queue of closed polygons awaiting their result
	class perimeter_tracker;
		bit [SCALE_W-1:0] scale;
		bit [COORD_W-1:0] first_x, first_y, prev_x, prev_y;
		bit               have_first;
		bit [SUM_W-1:0]   length_sum;
		bit               sum_sat;
		int unsigned      vertex_count;
		perimeter_t       perimeter_q[$];
		int unsigned      mismatches;

		function new();
			scale = cpp_pkg::SCALE_RESET;
			mismatches = 0;
			clear_polygon();
		endfunction

		function void clear_polygon();
			first_x = '0;
			first_y = '0;
			prev_x = '0;
			prev_y = '0;
			have_first = 0;
			length_sum = '0;
			sum_sat = 0;
			vertex_count = 0;
		endfunction

		function int outstanding();
			return perimeter_q.size();
		endfunction

		// floor of the euclidean distance with FRAC_BITS fraction bits, bit by bit from the top
		function bit [ROOT_W-1:0] edge_length(bit [COORD_W-1:0] ax, bit [COORD_W-1:0] ay,
				bit [COORD_W-1:0] bx, bit [COORD_W-1:0] by);
			bit [COORD_W-1:0] dx, dy;
			bit [SQ_W-1:0]    sq;
			bit [63:0]        radicand;
			bit [ROOT_W-1:0]  root, trial;
			dx = (ax > bx) ? ax - bx : bx - ax;
			dy = (ay > by) ? ay - by : by - ay;
			sq = SQ_W'(dx) * SQ_W'(dx) + SQ_W'(dy) * SQ_W'(dy);
			radicand = 64'(sq) << (2 * FRAC_BITS);
			root = '0;
			for (int b = ROOT_W - 1; b >= 0; b--) begin
				trial = root | (ROOT_W'(1) << b);
				if (64'(trial) * 64'(trial) <= radicand)
					root = trial;
			end
			return root;
		endfunction

		// saturating accumulate
		function void add_length(bit [ROOT_W-1:0] len);
			bit [SUM_W:0] total;
			total = {1'b0, length_sum} + (SUM_W+1)'(len);
			if (total[SUM_W]) begin
				length_sum = {SUM_W{1'b1}};
				sum_sat = 1;
			end else begin
				length_sum = total[SUM_W-1:0];
			end
		endfunction

		function void note_vertex(bit [COORD_W-1:0] x, bit [COORD_W-1:0] y, bit last);
			perimeter_t       r;
			bit [PROD_W-1:0]  prod;
			bit [OUT_W:0]     q;
			if (!have_first) begin
				first_x = x;
				first_y = y;
				have_first = 1;
			end else begin
				add_length(edge_length(prev_x, prev_y, x, y));
			end
			prev_x = x;
			prev_y = y;
			vertex_count++;
			// a full polygon closes on its own
			if (vertex_count >= MAX_VERTICES)
				last = 1;
			if (!last)
				return;
			add_length(edge_length(x, y, first_x, first_y));
			// scale and round up
			prod = PROD_W'(scale) * PROD_W'(length_sum);
			q = prod >> FRAC_BITS;
			if (prod[FRAC_BITS-1:0] != 0)
				q++;
			r.sat = sum_sat;
			if (q[OUT_W]) begin
				q = {1'b0, {OUT_W{1'b1}}};
				r.sat = 1;
			end
			r.perim = q[OUT_W-1:0];
			perimeter_q.push_back(r);
			clear_polygon();
		endfunction

		function void check_result(bit [OUT_W-1:0] perim, bit sat);
			perimeter_t exp_r;
			if (perimeter_q.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("%0t: unexpected result perimeter=%0d saturated=%0b",
						$realtime, perim, sat);
				mismatches++;
				return;
			end
			exp_r = perimeter_q.pop_front();
			if (exp_r.perim !== perim || exp_r.sat !== sat) begin
				if (mismatches < MAX_REPORTS)
					$display("%0t: mismatch perimeter exp=%0d got=%0d, saturated exp=%0b got=%0b",
						$realtime, exp_r.perim, perim, exp_r.sat, sat);
				mismatches++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cost_scale_we;
	logic [SCALE_W-1:0]     cost_scale_wdata;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // x_coord, y_coord
	logic                   s_tlast;   // last_vertex
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // scaled_perimeter
	logic                   m_tuser;   // saturated

	perimeter_tracker tracker;
	int unsigned      burst_left;
	int unsigned      vertices_sent;
	bit               hold_request;

	closed_polygon_perimeter dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cost_scale_we    (cost_scale_we),
		.cost_scale_wdata (cost_scale_wdata),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tlast          (s_tlast),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tuser          (m_tuser)
	);

	// clock
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#12ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// receiver stall pattern, with a long hold-off on request
	initial begin
		int unsigned ready_cycle;
		int unsigned mode;
		int unsigned hold_left;
		logic        nxt;
		m_tready = 0;
		ready_cycle = 0;
		mode = 0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			ready_cycle++;
			if (hold_request) begin
				hold_request = 0;
				hold_left = HOLD_CYCLES;
			end
			if (ready_cycle % 400 == 0)
				mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left--;
				nxt = 0;
			end else begin
				case (mode)
					0: nxt = 1;
					1: nxt = $urandom_range(0, 1);
					2: nxt = ($urandom_range(0, 7) == 0);
					default: nxt = ((ready_cycle / 5) % 3 != 0);
				endcase
			end
			m_tready <= nxt;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(m_tdata[OUT_W-1:0], m_tuser);
	end

	// offer one vertex request and wait for it to be taken; returns at a falling edge
	task automatic send_vertex(bit [COORD_W-1:0] x, bit [COORD_W-1:0] y, bit last);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			if (gap > 0) begin
				s_tvalid <= 0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_tdata <= {{(IN_TDATA_W - 2*COORD_W){1'b0}}, y, x};
		s_tlast <= last;
		s_tvalid <= 1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.note_vertex(x, y, last);
		burst_left--;
		vertices_sent++;
		@(negedge clk);
	endtask

	// stop offering and let every pending result drain
	task automatic wait_for_results();
		s_tvalid <= 0;
		burst_left = 0;
		while (tracker.outstanding() > 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_cost_scale(bit [SCALE_W-1:0] value);
		wait_for_results();
		cost_scale_wdata <= value;
		cost_scale_we <= 1;
		@(negedge clk);
		cost_scale_we <= 0;
		tracker.scale = value;
	endtask

	function automatic bit [COORD_W-1:0] pick_coord(bit [COORD_W-1:0] near);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return COORD_MAX;
			2: return near + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
			default: return COORD_W'($urandom_range(0, 32767));
		endcase
	endfunction

	task automatic send_random_polygon(int unsigned n);
		bit [COORD_W-1:0] x, y;
		x = COORD_W'($urandom_range(0, 32767));
		y = COORD_W'($urandom_range(0, 32767));
		for (int unsigned i = 0; i < n; i++) begin
			x = pick_coord(x);
			y = pick_coord(y);
			send_vertex(x, y, i == n - 1);
		end
	endtask

	// random polygons, mostly short
	task automatic random_phase(int unsigned count, bit with_hold);
		int unsigned target;
		int unsigned r;
		bit          hold_done;
		target = vertices_sent + count;
		hold_done = 0;
		while (vertices_sent < target) begin
			if (with_hold && !hold_done && vertices_sent + count / 2 >= target) begin
				hold_request = 1;
				hold_done = 1;
			end
			r = $urandom_range(0, 99);
			if (r < 60)
				send_random_polygon($urandom_range(1, 5));
			else if (r < 95)
				send_random_polygon($urandom_range(6, 30));
			else
				send_random_polygon($urandom_range(31, 120));
		end
	endtask

	initial begin
		tracker = new();
		burst_left = 0;
		vertices_sent = 0;
		hold_request = 0;
		arst_n = 0;
		cost_scale_we = 0;
		cost_scale_wdata = '0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tlast = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed, reset scale: single vertices, extremes, exact lengths, zero edges
		send_vertex('0, '0, 1);
		send_vertex(COORD_MAX, COORD_MAX, 1);
		send_vertex('0, '0, 0);
		send_vertex(COORD_MAX, COORD_MAX, 1);
		send_vertex('0, '0, 0);
		send_vertex(COORD_MAX, '0, 0);
		send_vertex('0, COORD_MAX, 1);
		send_vertex(15'd3, 15'd4, 0);
		send_vertex('0, '0, 1);
		send_vertex(15'd100, 15'd100, 0);
		send_vertex(15'd100, 15'd100, 1);
		send_vertex(15'h5555, 15'h2aaa, 0);
		send_vertex(15'h2aaa, 15'h5555, 0);
		send_vertex(15'd1, 15'd0, 1);

		// zero scale
		write_cost_scale('0);
		send_vertex(15'd7, 15'd9, 0);
		send_vertex(15'd20000, 15'd30000, 1);
		send_vertex(15'd5, 15'd5, 1);

		// unit scale, fractional perimeter rounds up
		write_cost_scale(8'd1);
		send_vertex(15'd0, 15'd0, 0);
		send_vertex(15'd1, 15'd1, 1);

		// full scale, then a polygon that closes on its vertex limit with no last flag
		write_cost_scale(8'd255);
		send_vertex(COORD_MAX, '0, 0);
		send_vertex('0, COORD_MAX, 1);
		for (int i = 0; i < MAX_VERTICES; i++)
			send_vertex((i % 2) ? COORD_MAX : '0, (i % 2) ? COORD_MAX : '0, 0);
		send_vertex(15'd10, 15'd10, 0);
		send_vertex(15'd13, 15'd14, 1);

		// random phases under several scales
		write_cost_scale(8'($urandom_range(2, 254)));
		random_phase(240, 1);
		write_cost_scale(8'd255);
		random_phase(240, 0);
		write_cost_scale(8'd1);
		random_phase(240, 0);
		write_cost_scale(8'($urandom_range(0, 255)));
		random_phase(240, 0);

		wait_for_results();
		if (tracker.mismatches == 0 && tracker.outstanding() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
